// ===== hw/rtl/boot_control_record_patcher_assert.svh =====
// Assertion helpers for the checker file.
`ifndef BOOT_CONTROL_RECORD_PATCHER_ASSERT_SVH
`define BOOT_CONTROL_RECORD_PATCHER_ASSERT_SVH

// Checked outside reset only.
`define BCRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define BCRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/bcrp_pkg.sv =====
package bcrp_pkg;

  localparam int unsigned RecordBytes = 32;
  localparam int unsigned CrcSpan     = 28;
  localparam int unsigned PosW        = $clog2(RecordBytes);

  localparam logic [31:0] CrcPoly   = 32'hedb8_8320;
  localparam logic [31:0] CrcInit   = 32'hffff_ffff;
  localparam logic [31:0] MagicWord = 32'h4241_4342;
  localparam logic [15:0] InfoMarked = 16'h00ff;

  localparam logic [PosW-1:0] MagicBase = PosW'(4);
  localparam logic [PosW-1:0] MagicLast = PosW'(7);
  localparam logic [PosW-1:0] InfoBase  = PosW'(12);
  localparam logic [PosW-1:0] InfoBase1 = PosW'(14);
  localparam logic [PosW-1:0] CrcFirst  = PosW'(CrcSpan);
  localparam logic [PosW-1:0] LastPos   = PosW'(RecordBytes - 1);

  typedef enum logic [1:0] {
    REG_PATCH_MODE  = 2'd0,
    REG_ACTIVE_SLOT = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic       patch_mode;
    logic [1:0] active_slot;
  } cfg_t;

  typedef struct packed {
    logic       slot_successful;
    logic [2:0] slot_tries;
    logic [3:0] slot_priority;
    logic       info_slot;
    logic       info_valid;
    logic       magic_valid;
    logic       record_end;
    logic [7:0] patched_byte;
  } res_t;

  // Reflected CRC-32, one byte folded in.
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/boot_control_record_patcher.sv =====
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] record_byte, tuser[0] record_start
// m_axis   | out       | tdata patched byte and slot fields, tuser info flags,
//          |           | tlast record_end
// cfg      | in        | cfg_addr_i register index, cfg_data_i value
//
// One byte per cycle sustained while m_axis_tready is high; results are registered.
// The byte CRC is a single unrolled step between the record state and the
// output register. A skid register keeps s_axis_tready high for one stalled
// result; a second stalled result drops tready. Reset clears position and magic
// flag, presets CRC, empties both output stages; the cfg channel is always ready.
module boot_control_record_patcher import bcrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  s_axis_tdata,   // [7:0] record_byte
  input  logic        s_axis_tuser,   // [0] record_start
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] patched_byte, [8] magic_valid,
                                      // [12:9] slot_priority, [15:13] slot_tries,
                                      // [16] slot_successful, [23:17] zero
  output logic [1:0]  m_axis_tuser,   // [0] info_valid, [1] info_slot
  output logic        m_axis_tlast,   // record_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [1:0]  cfg_data_i
);

  cfg_t cfg_q;
  res_t res;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.patch_mode  <= 1'b1;
      cfg_q.active_slot <= 2'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_PATCH_MODE:  cfg_q.patch_mode  <= cfg_data_i[0];
        REG_ACTIVE_SLOT: cfg_q.active_slot <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcrp_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .start_i  (s_axis_tuser),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      // Output stage drains: refill from skid first, else from the new transfer.
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.record_end;
  assign m_axis_tuser  = {out_q.info_slot, out_q.info_valid};
  assign m_axis_tdata  = {7'h00, out_q.slot_successful, out_q.slot_tries,
                          out_q.slot_priority, out_q.magic_valid, out_q.patched_byte};

endmodule

// ===== hw/rtl/bcrp_datapath.sv =====
module bcrp_datapath import bcrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic            magic_q, magic_d;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] slot_lo;
  logic [31:0]     crc_base;
  logic [31:0]     crc_fin;
  logic            magic_base;
  logic [7:0]      want;
  logic            patch;
  logic [7:0]      o;
  logic            info_hit;

  always_comb begin
    pos        = start_i ? '0 : pos_q;
    crc_base   = (pos == '0) ? CrcInit : crc_q;
    magic_base = (pos == '0) ? 1'b0 : magic_q;
    want       = MagicWord[{pos[1:0], 3'b000} +: 8];
    slot_lo    = InfoBase + (PosW'(cfg_i.active_slot) << 1);

    magic_d = magic_base;
    if (pos >= MagicBase && pos <= MagicLast) begin
      if (pos == MagicBase) begin
        magic_d = (byte_i == want);
      end else begin
        magic_d = magic_base && (byte_i == want);
      end
    end

    patch = cfg_i.patch_mode && magic_d && (pos >= MagicLast);

    o = byte_i;
    if (patch && pos == slot_lo) begin
      o = InfoMarked[7:0];
    end else if (patch && pos == slot_lo + PosW'(1)) begin
      o = InfoMarked[15:8];
    end

    crc_fin = ~crc_base;
    crc_d   = crc_base;
    if (pos < CrcFirst) begin
      crc_d = crc_byte(crc_base, o);
    end else if (patch) begin
      o = crc_fin[{pos[1:0], 3'b000} +: 8];
    end

    pos_d    = pos + PosW'(1);
    info_hit = (pos == InfoBase) || (pos == InfoBase1);

    res_o.patched_byte    = o;
    res_o.record_end      = (pos == LastPos);
    res_o.magic_valid     = magic_d && (pos >= MagicLast);
    res_o.info_valid      = info_hit;
    res_o.info_slot       = info_hit && (pos == InfoBase1);
    res_o.slot_priority   = info_hit ? byte_i[3:0] : 4'h0;
    res_o.slot_tries      = info_hit ? byte_i[6:4] : 3'h0;
    res_o.slot_successful = info_hit && byte_i[7];
  end

  // Advance record state on each input transfer only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      magic_q <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      magic_q <= magic_d;
    end
  end

endmodule

// ===== hw/rtl/bcrp_checker.sv =====
`include "boot_control_record_patcher_assert.svh"

module bcrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_addr_i,
  input logic [1:0]  cfg_data_i
);

  `BCRP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output transfer changed")

  `BCRP_ASSERT(a_stall_only_when_full, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

  `BCRP_ASSERT(a_last_not_info, m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0], "record end flagged on an info byte")

  `BCRP_ASSERT(a_fields_zero, m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1] && (m_axis_tdata[16:9] == 8'h00), "slot fields set outside an info byte")

  `BCRP_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

bind boot_control_record_patcher bcrp_checker u_bcrp_checker (.*);

// ===== bench/boot_control_record_patcher_test.sv =====
`timescale 1ns / 1ps

module boot_control_record_patcher_test;
  import bcrp_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned HoldCycles = 120;
  // per-phase settings, phase n in bit n (slot in bits 2n+1..2n)
  localparam logic [6:0]  PhaseMode  = 7'b1001111;
  localparam logic [13:0] PhaseSlot  = {2'd1, 2'd0, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [1:0]  cfg_data_i = '0;

  class patch_scoreboard;
    logic        mode;
    logic [1:0]  slot;
    logic [4:0]  pos;
    logic [31:0] crc;
    logic        magic;
    res_t        patched_q[$];
    int          errors;

    function new();
      mode   = 1'b1;
      slot   = 2'd0;
      pos    = '0;
      crc    = CrcInit;
      magic  = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [1:0] val);
      case (idx)
        REG_PATCH_MODE:  mode = val[0];
        REG_ACTIVE_SLOT: slot = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] crc32_fold(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ d[i];
        r  = r >> 1;
        if (fb) r = r ^ CrcPoly;
      end
      return r;
    endfunction

    function void note_input(logic [7:0] b, logic st);
      res_t        r;
      logic [4:0]  p;
      logic [4:0]  slot_lo;
      logic        hit;
      logic [7:0]  o;
      logic [31:0] fin;
      int          k;
      p = st ? 5'd0 : pos;
      if (p == 5'd0) begin
        crc   = CrcInit;
        magic = 1'b0;
      end
      if (p >= MagicBase && p <= MagicLast) begin
        k = int'(p - MagicBase);
        if (p == MagicBase) magic = (b == MagicWord[8*k +: 8]);
        else magic = magic && (b == MagicWord[8*k +: 8]);
      end
      hit     = mode && magic && (p >= MagicLast);
      slot_lo = InfoBase + {2'b00, slot, 1'b0};
      o       = b;
      if (hit && p == slot_lo) o = InfoMarked[7:0];
      else if (hit && p == slot_lo + 5'd1) o = InfoMarked[15:8];
      // fold the outgoing byte, or send the finished CRC LSB first
      if (p < CrcFirst) begin
        crc = crc32_fold(crc, o);
      end else if (hit) begin
        fin = ~crc;
        k   = int'(p - CrcFirst);
        o   = fin[8*k +: 8];
      end
      r              = '0;
      r.patched_byte = o;
      r.record_end   = (p == LastPos);
      r.magic_valid  = magic && (p >= MagicLast);
      if (p == InfoBase || p == InfoBase1) begin
        r.info_valid      = 1'b1;
        r.info_slot       = (p == InfoBase1);
        r.slot_priority   = b[3:0];
        r.slot_tries      = b[6:4];
        r.slot_successful = b[7];
      end
      patched_q.push_back(r);
      pos = p + 5'd1;
    endfunction

    function void check_result(logic [23:0] td, logic [1:0] tu, logic tl);
      res_t want;
      res_t got;
      got.patched_byte    = td[7:0];
      got.magic_valid     = td[8];
      got.slot_priority   = td[12:9];
      got.slot_tries      = td[15:13];
      got.slot_successful = td[16];
      got.info_valid      = tu[0];
      got.info_slot       = tu[1];
      got.record_end      = tl;
      if (patched_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: tdata %h tuser %b tlast %b", td, tu, tl);
        return;
      end
      want = patched_q.pop_front();
      if (got !== want || td[23:17] !== 7'd0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: byte %h end %b magic %b info %b slot %b",
                   want.patched_byte, want.record_end, want.magic_valid,
                   want.info_valid, want.info_slot);
          $display("          exp: pri %h tries %h ok %b",
                   want.slot_priority, want.slot_tries, want.slot_successful);
          $display("         got: byte %h end %b magic %b info %b slot %b",
                   got.patched_byte, got.record_end, got.magic_valid,
                   got.info_valid, got.info_slot);
          $display("          got: pri %h tries %h ok %b pad %h",
                   got.slot_priority, got.slot_tries, got.slot_successful,
                   td[23:17]);
        end
      end
    endfunction
  endclass

  patch_scoreboard board;
  logic [4:0]      stream_pos = '0;
  bit              src_idle_on = 1'b1;
  bit              sink_idle_on = 1'b1;
  bit              hold_req = 1'b0;
  int              items_sent = 0;

  boot_control_record_patcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic push_item(input logic [7:0] b, input logic st);
    while (src_idle_on && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(b, st);
    stream_pos = st ? 5'd1 : stream_pos + 5'd1;
    items_sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (board.patched_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [1:0] slot);
    cfg_addr_i  <= REG_PATCH_MODE;
    cfg_data_i  <= {1'b0, mode};
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(REG_PATCH_MODE, {1'b0, mode});
    cfg_addr_i <= REG_ACTIVE_SLOT;
    cfg_data_i <= slot;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(REG_ACTIVE_SLOT, slot);
    cfg_valid_i <= 1'b0;
  endtask

  // Send the first len bytes of a record; at byte pause_at, drain and flip the slot.
  task automatic send_record(input int len, input int pause_at);
    logic [7:0] rec [32];
    logic       st;
    for (int i = 0; i < 32; i++) rec[i] = 8'($urandom_range(0, 255));
    if (pause_at >= 0 || $urandom_range(0, 99) < 85) begin
      for (int i = 0; i < 4; i++) rec[MagicBase + 5'(i)] = MagicWord[8*i +: 8];
      if (pause_at < 0 && $urandom_range(0, 99) < 15)
        rec[MagicBase + 5'($urandom_range(0, 3))] ^= 8'($urandom_range(1, 255));
    end
    // skip the start flag now and then when the stream is already aligned
    st = (stream_pos != 5'd0) || ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) begin
      if (i == pause_at) begin
        wait_drain();
        set_config(board.mode, ~board.slot);
      end
      push_item(rec[i], (i == 0) ? st : 1'b0);
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: mark mode, slot 0
    push_item(8'hff, 1'b1);
    for (int i = 1; i < 4; i++) push_item(8'h00, 1'b0);
    for (int i = 0; i < 4; i++) push_item(MagicWord[8*i +: 8], 1'b0);
    for (int i = 8; i < 12; i++) push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h5a, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    // abandon the record with a fresh start, then break the last magic byte
    push_item(8'h00, 1'b1);
    for (int i = 1; i < 4; i++) push_item(8'ha5, 1'b0);
    push_item(MagicWord[7:0], 1'b0);
    push_item(MagicWord[15:8], 1'b0);
    push_item(MagicWord[23:16], 1'b0);
    push_item(MagicWord[7:0] ^ 8'h01, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drain();
      set_config(PhaseMode[ph], PhaseSlot[2*ph +: 2]);
      src_idle_on  = (ph != 1);
      sink_idle_on = (ph != 1);
      if (ph == 2) hold_req = 1'b1;
      if (ph == 3) send_record(32, 16);
      while (items_sent < 100 * (ph + 1) + 24) begin
        if ($urandom_range(0, 99) < 5)
          repeat ($urandom_range(1, 4))
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_record(($urandom_range(0, 99) < 8) ? $urandom_range(1, 31) : 32, -1);
      end
    end

    wait_drain();
    repeat (4) @(posedge clk_i);
    if (board.errors == 0 && board.patched_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      // hold off long enough for the skid stage to fill and tready to drop
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !sink_idle_on || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bcrp_pkg.sv
hw/rtl/bcrp_datapath.sv
hw/rtl/boot_control_record_patcher.sv
hw/rtl/bcrp_checker.sv
bench/boot_control_record_patcher_test.sv
